// ===== rtl/core/clrd_pkg.sv =====
// ----------------------------------------------------------------------------
// clrd_pkg
// Shared types and constants of the column run-length map decoder.
// ----------------------------------------------------------------------------
package clrd_pkg;

   // Default geometry of the map and its file header.
   localparam int COLUMN_CELLS_DEF = 64;
   localparam int MAX_COLUMNS_DEF  = 240;
   localparam int HEADER_BYTES_DEF = 27;

   // Header byte positions of the little-endian map width.
   localparam int WIDTH_LO_IDX = 2;
   localparam int WIDTH_HI_IDX = 3;

   // A run holds at most 64 cells, so seven bits carry any run length.
   localparam int RUN_W = 7;

   // Body byte forms, taken from bits 7..6.
   localparam logic [1:0] FORM_LITERAL = 2'b00;
   localparam logic [1:0] FORM_SHORT   = 2'b01;
   localparam logic [1:0] FORM_ZERO    = 2'b10;
   localparam logic [1:0] FORM_SINGLE  = 2'b11;

   // Decoder status codes.
   localparam logic [1:0] ST_DECODING  = 2'd0;
   localparam logic [1:0] ST_COMPLETE  = 2'd1;
   localparam logic [1:0] ST_TRUNCATED = 2'd2;
   localparam logic [1:0] ST_BAD_WIDTH = 2'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;   // take the input word and update the decoder state
      logic emit;     // load the next result into the output register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic produces;   // the word on the input side gives results
      logic last_item;  // the pending run has one result left
      logic out_free;   // the output register can take a result
   } sts_type;

endpackage

// ===== rtl/core/clrd_ctrl.sv =====
// ----------------------------------------------------------------------------
// clrd_ctrl
// Controller: takes one input word, then paces its results into the output.
// ----------------------------------------------------------------------------
module clrd_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  clrd_pkg::sts_type sts,
   output clrd_pkg::cmd_type cmd
);
   import clrd_pkg::*;

   typedef enum logic {
      S_IDLE,
      S_EMIT
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_tready = (state_ff == S_IDLE);
   assign cmd.accept = req_tvalid && (state_ff == S_IDLE);
   assign cmd.emit   = (state_ff == S_EMIT) && sts.out_free;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (cmd.accept && sts.produces) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (cmd.emit && sts.last_item) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/core/clrd_datapath.sv =====
// ----------------------------------------------------------------------------
// clrd_datapath
// Datapath: header parsing, run decode, run counters and output register.
// ----------------------------------------------------------------------------
module clrd_datapath #(
   parameter int COLUMN_CELLS = clrd_pkg::COLUMN_CELLS_DEF,
   parameter int MAX_COLUMNS  = clrd_pkg::MAX_COLUMNS_DEF,
   parameter int HEADER_BYTES = clrd_pkg::HEADER_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [7:0]        req_tdata,
   input  logic              req_tlast,
   input  clrd_pkg::cmd_type cmd,
   output clrd_pkg::sts_type sts,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [23:0]       rsp_tdata,
   output logic              rsp_tuser,
   output logic              rsp_tlast
);
   import clrd_pkg::*;

   localparam int ROW_W = (COLUMN_CELLS > 2) ? $clog2(COLUMN_CELLS) : 1;
   localparam int REM_W = $clog2(COLUMN_CELLS + 1);
   localparam int CMP_W = (REM_W > RUN_W) ? REM_W : RUN_W;
   localparam int HC_W  = $clog2(HEADER_BYTES + 1);

   // Decoder state.
   logic [HC_W-1:0]  hdr_ff,     hdr_in;
   logic [7:0]       map_ff,     map_in;
   logic [7:0]       col_ff,     col_in;
   logic [ROW_W-1:0] row_ff,     row_in;
   logic             lit_ff,     lit_in;
   logic [RUN_W-1:0] pend_ff,    pend_in;
   logic [1:0]       fin_ff,     fin_in;

   // Run that is being played out.
   logic [7:0]       run_tile_ff,   run_tile_in;
   logic [ROW_W-1:0] run_row_ff,    run_row_in;
   logic [7:0]       run_col_ff,    run_col_in;
   logic             run_valid_ff,  run_valid_in;
   logic [RUN_W-1:0] run_left_ff,   run_left_in;
   logic [1:0]       run_status_ff, run_status_in;

   // Output register.
   logic             out_vld_ff,    out_vld_in;
   logic [7:0]       out_tile_ff,   out_tile_in;
   logic [5:0]       out_row_ff,    out_row_in;
   logic [7:0]       out_col_ff,    out_col_in;
   logic             out_flag_ff,   out_flag_in;
   logic             out_last_ff,   out_last_in;
   logic [1:0]       out_status_ff, out_status_in;

   // Run decode of the current word.
   logic             is_run;
   logic [RUN_W-1:0] cnt;
   logic [7:0]       tile;
   logic [CMP_W-1:0] remaining;
   logic [CMP_W-1:0] row_sum;
   logic             hit;
   logic [RUN_W-1:0] eff;
   logic [8:0]       col_next;
   logic [ROW_W+5:0] row_wide;

   assign remaining = CMP_W'(COLUMN_CELLS) - CMP_W'(row_ff);
   assign row_sum   = CMP_W'(row_ff) + CMP_W'(cnt);
   assign hit       = (CMP_W'(cnt) >= remaining);
   assign eff       = hit ? remaining[RUN_W-1:0] : cnt;
   assign col_next  = {1'b0, col_ff} + 9'd1;
   assign row_wide  = {6'd0, run_row_ff};

   always_comb begin
      is_run = 1'b0;
      cnt    = '0;
      tile   = '0;
      if (lit_ff) begin
         is_run = 1'b1;
         cnt    = pend_ff;
         tile   = req_tdata;
      end else begin
         case (req_tdata[7:6])
            FORM_LITERAL: begin
               is_run = 1'b0;
            end
            FORM_SHORT: begin
               is_run = 1'b1;
               cnt    = RUN_W'(req_tdata[5:4]) + RUN_W'(2);
               tile   = 8'(req_tdata[3:0]) + 8'd1;
            end
            FORM_ZERO: begin
               is_run = (req_tdata[5:0] != 6'd0);
               cnt    = RUN_W'(req_tdata[5:0]);
            end
            FORM_SINGLE: begin
               is_run = 1'b1;
               cnt    = RUN_W'(1);
               tile   = 8'(req_tdata[5:0]);
            end
            default: begin
               is_run = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      hdr_in        = hdr_ff;
      map_in        = map_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      lit_in        = lit_ff;
      pend_in       = pend_ff;
      fin_in        = fin_ff;
      run_tile_in   = run_tile_ff;
      run_row_in    = run_row_ff;
      run_col_in    = run_col_ff;
      run_valid_in  = run_valid_ff;
      run_left_in   = run_left_ff;
      run_status_in = run_status_ff;

      if (cmd.accept && (fin_ff == ST_DECODING)) begin
         // Default is a single status-only result.
         run_tile_in  = '0;
         run_row_in   = '0;
         run_col_in   = '0;
         run_valid_in = 1'b0;
         run_left_in  = RUN_W'(1);

         if (hdr_ff < HC_W'(HEADER_BYTES)) begin
            if (hdr_ff == HC_W'(WIDTH_LO_IDX)) begin
               map_in = req_tdata;
            end else if (hdr_ff == HC_W'(WIDTH_HI_IDX)) begin
               if ((req_tdata != 8'd0) || (map_ff > 8'(MAX_COLUMNS))) begin
                  map_in = '0;
               end
            end
            hdr_in = hdr_ff + HC_W'(1);
            if ((hdr_in == HC_W'(HEADER_BYTES)) && (map_in == 8'd0)) begin
               fin_in = ST_BAD_WIDTH;
            end
         end else begin
            if (lit_ff) begin
               lit_in = 1'b0;
            end else if (req_tdata[7:6] == FORM_LITERAL) begin
               lit_in  = 1'b1;
               pend_in = RUN_W'(req_tdata[5:0]) + RUN_W'(1);
            end
            if (is_run) begin
               run_tile_in  = tile;
               run_row_in   = row_ff;
               run_col_in   = col_ff;
               run_valid_in = 1'b1;
               run_left_in  = eff;
               if (hit) begin
                  row_in = '0;
                  col_in = col_next[7:0];
                  if (col_next >= {1'b0, map_ff}) begin
                     fin_in = ST_COMPLETE;
                  end
               end else begin
                  row_in = row_sum[ROW_W-1:0];
               end
            end
         end

         if (req_tlast && (fin_in == ST_DECODING)) begin
            fin_in = ST_TRUNCATED;
         end
         run_status_in = fin_in;
      end else if (cmd.emit) begin
         run_row_in  = run_row_ff + ROW_W'(1);
         run_left_in = run_left_ff - RUN_W'(1);
      end
   end

   always_comb begin
      out_vld_in    = out_vld_ff;
      out_tile_in   = out_tile_ff;
      out_row_in    = out_row_ff;
      out_col_in    = out_col_ff;
      out_flag_in   = out_flag_ff;
      out_last_in   = out_last_ff;
      out_status_in = out_status_ff;
      if (cmd.emit) begin
         out_vld_in    = 1'b1;
         out_tile_in   = run_tile_ff;
         out_row_in    = row_wide[5:0];
         out_col_in    = run_col_ff;
         out_flag_in   = run_valid_ff;
         out_last_in   = (run_left_ff == RUN_W'(1));
         out_status_in = run_status_ff;
      end else if (rsp_tready) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_ff     <= '0;
         map_ff     <= '0;
         col_ff     <= '0;
         row_ff     <= '0;
         lit_ff     <= 1'b0;
         pend_ff    <= '0;
         fin_ff     <= ST_DECODING;
         out_vld_ff <= 1'b0;
      end else begin
         hdr_ff     <= hdr_in;
         map_ff     <= map_in;
         col_ff     <= col_in;
         row_ff     <= row_in;
         lit_ff     <= lit_in;
         pend_ff    <= pend_in;
         fin_ff     <= fin_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      run_tile_ff   <= run_tile_in;
      run_row_ff    <= run_row_in;
      run_col_ff    <= run_col_in;
      run_valid_ff  <= run_valid_in;
      run_left_ff   <= run_left_in;
      run_status_ff <= run_status_in;
      out_tile_ff   <= out_tile_in;
      out_row_ff    <= out_row_in;
      out_col_ff    <= out_col_in;
      out_flag_ff   <= out_flag_in;
      out_last_ff   <= out_last_in;
      out_status_ff <= out_status_in;
   end

   assign sts.produces  = (fin_ff == ST_DECODING);
   assign sts.last_item = (run_left_ff == RUN_W'(1));
   assign sts.out_free  = !out_vld_ff || rsp_tready;

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {out_status_ff, out_col_ff, out_row_ff, out_tile_ff};
   assign rsp_tuser  = out_flag_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

// ===== rtl/core/column_run_length_map_decoder.sv =====
// ----------------------------------------------------------------------------
// column_run_length_map_decoder
// Decodes a column run-length map file, one byte per word, into cell writes.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Word contents
//   req_*     in         tdata: file byte; tlast: final byte of the file
//   rsp_*     out        tdata: tile, row, column, status; tuser: tile valid;
//                        tlast: last result of the input byte
//
// The controller accepts an input byte and then plays out its results into
// the output register, one per cycle while the result side does not stall.
// A byte after the map has finished gives no result. The decoder accepts no
// byte while a run plays out.
// Reset is synchronous and active high; it clears the decoder state at once.
// A stall on the result side holds the output register and pauses the run.
//
// The header is skipped after the width is taken from its third and fourth
// bytes. Each body byte that yields a run writes its cells down the current
// column, cut at the bottom of the column. Every result of one byte carries
// the status as it stands after that byte, so the run length and the next
// status are settled when the byte is accepted.
//
module column_run_length_map_decoder #(
   parameter int COLUMN_CELLS = clrd_pkg::COLUMN_CELLS_DEF,
   parameter int MAX_COLUMNS  = clrd_pkg::MAX_COLUMNS_DEF,
   parameter int HEADER_BYTES = clrd_pkg::HEADER_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // stream_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] tile_value, [13:8] cell_row,
                                    // [21:14] cell_column, [23:22] status
   output logic        rsp_tuser,   // [0] tile_valid
   output logic        rsp_tlast    // run_last
);
   import clrd_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // The controller sequences acceptance and result playout.
   clrd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // The datapath holds the decoder state, the pending run and the output.
   clrd_datapath #(
      .COLUMN_CELLS (COLUMN_CELLS),
      .MAX_COLUMNS  (MAX_COLUMNS),
      .HEADER_BYTES (HEADER_BYTES)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
